/* hw/rtl/ialu_pkg.sv */
// ialu_pkg: opcodes, status codes and operand type tags for the integer alu
// no dependencies

package ialu_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9,
        OP_GE  = 4'd10,
        OP_LE  = 4'd11,
        OP_LT  = 4'd12,
        OP_GT  = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_OP = 2'd1,
        ST_DIV0   = 2'd2
    } t_status;

    localparam logic [1:0] TYPE_S8  = 2'd0;
    localparam logic [1:0] TYPE_S16 = 2'd1;

    function automatic logic [DataW-1:0] widen(input logic [DataW-1:0] raw,
                                               input logic [1:0] tag);
        logic [DataW-1:0] v;
        begin
            case (tag)
                TYPE_S8:  v = {{(DataW-8){raw[7]}}, raw[7:0]};
                TYPE_S16: v = {{(DataW-16){raw[15]}}, raw[15:0]};
                default:  v = raw;
            endcase
            return v;
        end
    endfunction

endpackage

/* hw/rtl/ialu_div.sv */
// ialu_div: pipelined unsigned divider, two quotient bits per stage, 16 stages
// depends on ialu_pkg

module ialu_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ialu_pkg::DataW-1:0]  i_num,
    input  logic [ialu_pkg::DataW-1:0]  i_den,
    output logic [ialu_pkg::DataW-1:0]  o_quo,
    output logic [ialu_pkg::DataW-1:0]  o_rem
);
    import ialu_pkg::*;

    localparam int unsigned Stages = DataW / 2;

    logic [DataW-1:0] r_num [Stages];
    logic [DataW-1:0] r_rem [Stages];
    logic [DataW-1:0] r_den [Stages-1];
    logic [Stages-2:0] r_vld;

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic [DataW-1:0] c_num;
        logic [DataW-1:0] c_den;
        logic [DataW-1:0] c_rem;
        logic             c_vld;
        logic [DataW-1:0] n_num;
        logic [DataW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign c_num = i_num;
            assign c_den = i_den;
            assign c_rem = '0;
            assign c_vld = i_valid;
        end else begin : g_next
            assign c_num = r_num[s-1];
            assign c_den = r_den[s-1];
            assign c_rem = r_rem[s-1];
            assign c_vld = r_vld[s-1];
        end

        always_comb begin
            logic [DataW:0] t;
            logic [DataW-1:0] rem;
            logic [DataW-1:0] num;
            rem = c_rem;
            num = c_num;
            for (int k = 0; k < 2; k++) begin
                t = {rem, num[DataW-1]} - {1'b0, c_den};
                num = {num[DataW-2:0], ~t[DataW]};
                rem = t[DataW] ? {rem[DataW-2:0], c_num[DataW-1-k]} : t[DataW-1:0];
            end
            n_num = num;
            n_rem = rem;
        end

        always_ff @(posedge i_clk) begin
            if (c_vld) begin
                r_num[s] <= n_num;
                r_rem[s] <= n_rem;
            end
        end

        if (s < Stages - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= c_vld;
                end
                if (c_vld) begin
                    r_den[s] <= c_den;
                end
            end
        end
    end

    assign o_quo = r_num[Stages-1];
    assign o_rem = r_rem[Stages-1];

endmodule

/* hw/rtl/integer_alu_with_compare_top.sv */
// integer_alu_with_compare_top: 32-bit integer alu with compare, pipelined
// depends on ialu_pkg and ialu_div
//
//  channel | handshake          | fields
//  --------+--------------------+---------------------------------------------
//  in      | i_start / o_busy   | i_kind i_operand_a i_operand_b i_a_type i_b_type
//  out     | o_valid            | o_result o_status
//
// one word per cycle for every opcode, through a widen stage, 16 divider stages
// of two bits each, and a sign fix into the output register
// o_busy is held low: the pipeline never stalls and the receiver cannot stall
// synchronous active-low reset clears all valid bits

module integer_alu_with_compare_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_kind,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic [1:0]  i_a_type,
    input  logic [1:0]  i_b_type,
    output logic        o_valid,
    output logic signed [31:0] o_result,
    output logic [1:0]  o_status
);
    import ialu_pkg::*;

    localparam int unsigned Lat = DataW / 2;

    // stage 1: widen, simple ops, product, status and operand magnitudes for the divider
    logic             r_v1;
    logic [DataW-1:0] r_simple1, r_ma, r_mb;
    logic [1:0]       r_st1;
    logic             r_isdiv1, r_ismod1, r_qneg1, r_rneg1;

    logic [DataW-1:0] a_w, b_w, n_simple;
    logic [1:0]       n_st;
    logic             lt_ab, lt_ba;

    always_comb begin
        a_w = widen(i_operand_a, i_a_type);
        b_w = widen(i_operand_b, i_b_type);
        lt_ab = $signed(a_w) < $signed(b_w);
        lt_ba = $signed(b_w) < $signed(a_w);
        n_st = ST_OK;
        n_simple = '0;
        case (i_kind)
            OP_ADD: n_simple = a_w + b_w;
            OP_SUB: n_simple = a_w - b_w;
            OP_MUL: n_simple = a_w * b_w;
            OP_DIV, OP_MOD: begin
                if (b_w == '0) n_st = ST_DIV0;
            end
            OP_AND: n_simple = a_w & b_w;
            OP_OR:  n_simple = a_w | b_w;
            OP_XOR: n_simple = a_w ^ b_w;
            OP_EQ:  n_simple = {{(DataW-1){1'b0}}, a_w == b_w};
            OP_NE:  n_simple = {{(DataW-1){1'b0}}, a_w != b_w};
            OP_GE:  n_simple = {{(DataW-1){1'b0}}, ~lt_ab};
            OP_LE:  n_simple = {{(DataW-1){1'b0}}, ~lt_ba};
            OP_LT:  n_simple = {{(DataW-1){1'b0}}, lt_ab};
            OP_GT:  n_simple = {{(DataW-1){1'b0}}, lt_ba};
            default: n_st = ST_BAD_OP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        r_simple1 <= n_simple;
        r_st1     <= n_st;
        r_isdiv1  <= (i_kind == OP_DIV) && (n_st == ST_OK);
        r_ismod1  <= (i_kind == OP_MOD) && (n_st == ST_OK);
        r_qneg1   <= a_w[DataW-1] ^ b_w[DataW-1];
        r_rneg1   <= a_w[DataW-1];
        r_ma      <= a_w[DataW-1] ? (~a_w + 1'b1) : a_w;
        r_mb      <= b_w[DataW-1] ? (~b_w + 1'b1) : b_w;
    end

    // side line alongside the divider
    typedef struct packed {
        logic [DataW-1:0] simple;
        logic [1:0]       st;
        logic             isdiv;
        logic             ismod;
        logic             qneg;
        logic             rneg;
    } t_side;

    t_side            r_side [Lat];
    logic [Lat-1:0]   r_vs;
    logic [DataW-1:0] quo, rem;

    ialu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_num   (r_ma),
        .i_den   (r_mb),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= '0;
        end else begin
            r_vs <= {r_vs[Lat-2:0], r_v1};
        end
        r_side[0] <= '{simple: r_simple1, st: r_st1, isdiv: r_isdiv1,
                       ismod: r_ismod1, qneg: r_qneg1, rneg: r_rneg1};
        for (int i = 1; i < Lat; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // final: sign fix and output register
    t_side            last;
    logic [DataW-1:0] n_res;
    logic             r_valid;
    logic [DataW-1:0] r_res;
    logic [1:0]       r_status;

    always_comb begin
        last = r_side[Lat-1];
        if (last.isdiv) begin
            n_res = last.qneg ? (~quo + 1'b1) : quo;
        end else if (last.ismod) begin
            n_res = last.rneg ? (~rem + 1'b1) : rem;
        end else begin
            n_res = last.simple;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vs[Lat-1];
        end
        r_res    <= n_res;
        r_status <= last.st;
    end

    assign o_busy   = 1'b0;
    assign o_valid  = r_valid;
    assign o_result = r_res;
    assign o_status = r_status;

endmodule

/* hw/rtl/ialu_checker.sv */
// ialu_checker: port-level assertions for the integer alu
// depends on ialu_pkg; bound to integer_alu_with_compare_top

module ialu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [31:0] o_result,
    input logic [1:0]  o_status
);
    import ialu_pkg::*;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 18))
        else $error("word without matching start");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result == '0))
        else $error("nonzero result on error");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_BAD_OP || o_status == ST_DIV0))
        else $error("bad status");

endmodule

bind integer_alu_with_compare_top ialu_checker u_ialu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result),
    .o_status (o_status)
);
